// ===== src/whs_pkg.sv =====
`timescale 1ns / 1ps

package whs_pkg;

   localparam int DEF_MAX_WINDOW   = 16;
   localparam int DEF_KMER_ID_BITS = 32;

   localparam int KMER_ID_W = 32;
   localparam int HASH_W    = 64;
   localparam int BUCKET_W  = 31;
   localparam int WL_W      = 5;
   localparam int BB_W      = 5;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HASH_SEED          = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_HASH_THRESHOLD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BUCKET_BITS        = 3'd3;

   localparam logic [WL_W-1:0]   RST_WINDOW_LENGTH = 5'd4;
   localparam logic [HASH_W-1:0] RST_HASH_SEED     = 64'd0;
   localparam logic [HASH_W-1:0] RST_THRESHOLD     = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [BB_W-1:0]   RST_BUCKET_BITS   = 5'd20;

   // MurmurHash64A mixing constant, split for the 32x32 multiplier
   localparam logic [HASH_W-1:0] MM_MUL   = 64'hC6A4_A793_5BD1_E995;
   localparam logic [31:0]       MM_MUL_LO = MM_MUL[31:0];
   localparam logic [31:0]       MM_MUL_HI = MM_MUL[63:32];
   localparam int                MM_SHIFT = 47;

   // microprogram
   localparam int UPC_W = 5;
   localparam logic [UPC_W-1:0] UPC_PAIR_LOOP = 5'd5;
   localparam logic [UPC_W-1:0] UPC_ODD_CHECK = 5'd18;
   localparam logic [UPC_W-1:0] UPC_FINALISE  = 5'd24;

   typedef enum logic [3:0] {
      UOP_NOP,
      UOP_LDLEN,
      UOP_SEED,
      UOP_LDLO,
      UOP_LDHI,
      UOP_MUL0,
      UOP_MUL1,
      UOP_MUL2,
      UOP_SHK,
      UOP_XHK,
      UOP_SHH,
      UOP_DONE
   } uop_type;

   typedef enum logic {
      SRC_K,
      SRC_H
   } src_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_NO_PAIRS,
      COND_LOOP,
      COND_EVEN,
      COND_END
   } cond_type;

   typedef struct packed {
      uop_type          uop;
      src_type          src;
      cond_type         cond;
      logic [UPC_W-1:0] target;
   } ctrl_word_type;

   typedef struct packed {
      logic [KMER_ID_W-1:0] kmer_id;
      logic                 first_of_read;
      logic                 read_is_palindromic;
   } req_item_type;

   typedef struct packed {
      logic [HASH_W-1:0]   low_hash;
      logic [BUCKET_W-1:0] bucket_index;
   } rsp_item_type;

endpackage

// ===== src/whs_ucode_rom.sv =====
`timescale 1ns / 1ps

module whs_ucode_rom
   import whs_pkg::*;
(
   input  logic [UPC_W-1:0] addr,
   output ctrl_word_type    word
);

   always_comb begin
      word = '{uop: UOP_NOP, src: SRC_K, cond: COND_END, target: '0};
      unique case (addr)
         // initial value: h = seed ^ (len * 4 * m)
         5'd0:  word = '{uop: UOP_LDLEN, src: SRC_K, cond: COND_NEXT, target: '0};
         5'd1:  word = '{uop: UOP_MUL0,  src: SRC_K, cond: COND_NEXT, target: '0};
         5'd2:  word = '{uop: UOP_MUL1,  src: SRC_K, cond: COND_NEXT, target: '0};
         5'd3:  word = '{uop: UOP_MUL2,  src: SRC_K, cond: COND_NEXT, target: '0};
         5'd4:  word = '{uop: UOP_SEED,  src: SRC_K, cond: COND_NO_PAIRS,
                         target: UPC_ODD_CHECK};
         // one 64-bit block per pass
         5'd5:  word = '{uop: UOP_LDLO,  src: SRC_K, cond: COND_NEXT, target: '0};
         5'd6:  word = '{uop: UOP_LDHI,  src: SRC_K, cond: COND_NEXT, target: '0};
         5'd7:  word = '{uop: UOP_MUL0,  src: SRC_K, cond: COND_NEXT, target: '0};
         5'd8:  word = '{uop: UOP_MUL1,  src: SRC_K, cond: COND_NEXT, target: '0};
         5'd9:  word = '{uop: UOP_MUL2,  src: SRC_K, cond: COND_NEXT, target: '0};
         5'd10: word = '{uop: UOP_SHK,   src: SRC_K, cond: COND_NEXT, target: '0};
         5'd11: word = '{uop: UOP_MUL0,  src: SRC_K, cond: COND_NEXT, target: '0};
         5'd12: word = '{uop: UOP_MUL1,  src: SRC_K, cond: COND_NEXT, target: '0};
         5'd13: word = '{uop: UOP_MUL2,  src: SRC_K, cond: COND_NEXT, target: '0};
         5'd14: word = '{uop: UOP_XHK,   src: SRC_K, cond: COND_NEXT, target: '0};
         5'd15: word = '{uop: UOP_MUL0,  src: SRC_H, cond: COND_NEXT, target: '0};
         5'd16: word = '{uop: UOP_MUL1,  src: SRC_H, cond: COND_NEXT, target: '0};
         5'd17: word = '{uop: UOP_MUL2,  src: SRC_H, cond: COND_LOOP,
                         target: UPC_PAIR_LOOP};
         // trailing 4-byte tail
         5'd18: word = '{uop: UOP_NOP,   src: SRC_K, cond: COND_EVEN,
                         target: UPC_FINALISE};
         5'd19: word = '{uop: UOP_LDLO,  src: SRC_K, cond: COND_NEXT, target: '0};
         5'd20: word = '{uop: UOP_XHK,   src: SRC_K, cond: COND_NEXT, target: '0};
         5'd21: word = '{uop: UOP_MUL0,  src: SRC_H, cond: COND_NEXT, target: '0};
         5'd22: word = '{uop: UOP_MUL1,  src: SRC_H, cond: COND_NEXT, target: '0};
         5'd23: word = '{uop: UOP_MUL2,  src: SRC_H, cond: COND_NEXT, target: '0};
         // finaliser
         5'd24: word = '{uop: UOP_SHH,   src: SRC_H, cond: COND_NEXT, target: '0};
         5'd25: word = '{uop: UOP_MUL0,  src: SRC_H, cond: COND_NEXT, target: '0};
         5'd26: word = '{uop: UOP_MUL1,  src: SRC_H, cond: COND_NEXT, target: '0};
         5'd27: word = '{uop: UOP_MUL2,  src: SRC_H, cond: COND_NEXT, target: '0};
         5'd28: word = '{uop: UOP_SHH,   src: SRC_H, cond: COND_NEXT, target: '0};
         5'd29: word = '{uop: UOP_DONE,  src: SRC_H, cond: COND_END,  target: '0};
         default: word = '{uop: UOP_NOP, src: SRC_K, cond: COND_END, target: '0};
      endcase
   end

endmodule

// ===== src/whs_sequencer.sv =====
`timescale 1ns / 1ps

module whs_sequencer
   import whs_pkg::*;
#(
   parameter int MAX_WINDOW = DEF_MAX_WINDOW,
   localparam int CNT_W = $clog2(MAX_WINDOW + 1),
   localparam int LEN_W = (CNT_W > WL_W) ? CNT_W : WL_W
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             stall,
   input  logic [LEN_W-1:0] eff_len,
   output ctrl_word_type    ctrl,
   output logic             busy,
   output logic             step_en
);

   logic [UPC_W-1:0] upc_ff, upc_in;
   logic             busy_ff, busy_in;
   logic [LEN_W-1:0] cnt_ff, cnt_in;

   whs_ucode_rom u_rom (
      .addr (upc_ff),
      .word (ctrl)
   );

   assign busy    = busy_ff;
   assign step_en = busy_ff && !stall;

   always_comb begin
      upc_in  = upc_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         upc_in  = '0;
         busy_in = 1'b1;
      end else if (step_en) begin
         upc_in = upc_ff + 1'b1;
         if (ctrl.uop == UOP_SEED) begin
            cnt_in = eff_len >> 1;
         end
         case (ctrl.cond)
            COND_NO_PAIRS: begin
               if (eff_len < LEN_W'(2)) upc_in = ctrl.target;
            end
            COND_LOOP: begin
               cnt_in = cnt_ff - 1'b1;
               if (cnt_ff != LEN_W'(1)) upc_in = ctrl.target;
            end
            COND_EVEN: begin
               if (!eff_len[0]) upc_in = ctrl.target;
            end
            COND_END: begin
               busy_in = 1'b0;
               upc_in  = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff  <= '0;
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         upc_ff  <= upc_in;
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

// ===== src/whs_datapath.sv =====
`timescale 1ns / 1ps

module whs_datapath
   import whs_pkg::*;
#(
   parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
   parameter int KMER_ID_BITS = DEF_KMER_ID_BITS,
   localparam int CNT_W = $clog2(MAX_WINDOW + 1),
   localparam int LEN_W = (CNT_W > WL_W) ? CNT_W : WL_W,
   localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
)(
   input  logic                 clock,
   input  logic                 shift_en,
   input  logic [KMER_ID_W-1:0] kmer_id,
   input  logic                 step_en,
   input  ctrl_word_type        ctrl,
   input  logic [LEN_W-1:0]     eff_len,
   input  logic [HASH_W-1:0]    hash_seed,
   output logic [HASH_W-1:0]    hash
);

   logic [KMER_ID_BITS-1:0] win_ff [MAX_WINDOW];
   logic [KMER_ID_BITS-1:0] win_in [MAX_WINDOW];
   logic [IDX_W-1:0]        ptr_ff, ptr_in;
   logic [HASH_W-1:0]       k_ff, k_in;
   logic [HASH_W-1:0]       h_ff, h_in;
   logic [HASH_W-1:0]       acc_ff, acc_in;

   logic [HASH_W-1:0] mul_x;
   logic [31:0]       mul_a, mul_b;
   logic [63:0]       prod;
   logic [HASH_W-1:0] prod_hi_sum;
   logic [31:0]       rd_id;
   logic [LEN_W-1:0]  base;

   assign hash = h_ff;

   // newest id at the top of the window
   always_comb begin
      for (int i = 0; i < MAX_WINDOW - 1; i++) begin
         win_in[i] = shift_en ? win_ff[i + 1] : win_ff[i];
      end
      win_in[MAX_WINDOW - 1] = shift_en ? kmer_id[KMER_ID_BITS-1:0]
                                        : win_ff[MAX_WINDOW - 1];
   end

   assign rd_id = 32'(win_ff[ptr_ff]);
   assign base  = LEN_W'(MAX_WINDOW) - eff_len;

   // shared 32x32 multiplier: lo*lo, then the two cross terms into the upper word
   assign mul_x       = (ctrl.src == SRC_H) ? h_ff : k_ff;
   assign mul_a       = (ctrl.uop == UOP_MUL2) ? mul_x[63:32] : mul_x[31:0];
   assign mul_b       = (ctrl.uop == UOP_MUL1) ? MM_MUL_HI : MM_MUL_LO;
   assign prod        = mul_a * mul_b;
   assign prod_hi_sum = acc_ff + {prod[31:0], 32'b0};

   always_comb begin
      ptr_in = ptr_ff;
      k_in   = k_ff;
      h_in   = h_ff;
      acc_in = acc_ff;
      if (step_en) begin
         case (ctrl.uop)
            UOP_LDLEN: k_in = HASH_W'(eff_len) << 2;
            UOP_SEED: begin
               h_in   = hash_seed ^ k_ff;
               ptr_in = base[IDX_W-1:0];
            end
            UOP_LDLO: begin
               k_in   = {32'b0, rd_id};
               ptr_in = ptr_ff + 1'b1;
            end
            UOP_LDHI: begin
               k_in[63:32] = rd_id;
               ptr_in      = ptr_ff + 1'b1;
            end
            UOP_MUL0: acc_in = prod;
            UOP_MUL1: acc_in = prod_hi_sum;
            UOP_MUL2: begin
               if (ctrl.src == SRC_H) h_in = prod_hi_sum;
               else                   k_in = prod_hi_sum;
            end
            UOP_SHK: k_in = k_ff ^ (k_ff >> MM_SHIFT);
            UOP_XHK: h_in = h_ff ^ k_ff;
            UOP_SHH: h_in = h_ff ^ (h_ff >> MM_SHIFT);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      ptr_ff <= ptr_in;
      k_ff   <= k_in;
      h_ff   <= h_in;
      acc_ff <= acc_in;
   end

endmodule

// ===== src/windowed_low_hash_sketch.sv =====
`timescale 1ns / 1ps

// Windowed low-hash sketch.
// Ids arrive on the req_ channel, one id per beat; first_of_read starts a
// new read and empties the window. Once the current read has window_length ids,
// each beat hashes the last window_length ids (MurmurHash64A, 4 bytes per id)
// and, if the hash is below low_hash_threshold, one beat on the rsp_ channel
// carries the hash and its bucket index. Palindromic beats and short reads give
// nothing. Registers are written on the csr_ channel (always ready); the user
// must write them only while idle, since the block itself does not enforce it.
// A beat that needs no hash leaves the block ready. A hashed beat holds off
// req_ready until its microprogram ends; the single 32x32 multiplier, three
// passes per 64-bit product, sets the length of that microprogram.
// The result is registered: rsp_valid rises the cycle after the last microstep.
// If the receiver stalls, the finished result is held and the next beat is
// still taken; its hashing halts only at the last step while the earlier
// result waits. Reset restores register defaults and empties the window.
module windowed_low_hash_sketch
   import whs_pkg::*;
#(
   parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
   parameter int KMER_ID_BITS = DEF_KMER_ID_BITS
)(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_item_type         req_data,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_item_type         rsp_data,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int LEN_W = (CNT_W > WL_W) ? CNT_W : WL_W;

   logic [WL_W-1:0]   window_length_ff;
   logic [HASH_W-1:0] hash_seed_ff;
   logic [HASH_W-1:0] threshold_ff;
   logic [BB_W-1:0]   bucket_bits_ff;

   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_data_ff, rsp_data_in;

   logic              req_beat, csr_beat;
   logic [LEN_W-1:0]  wl_ext, eff_len;
   logic              start, stall, busy, step_en, hash_low, done_step;
   ctrl_word_type     ctrl;
   logic [HASH_W-1:0] hash;
   logic [31:0]       bucket_mask;

   assign csr_ready = 1'b1;
   assign csr_beat  = csr_valid && csr_ready;
   assign req_ready = !busy;
   assign req_beat  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= RST_WINDOW_LENGTH;
         hash_seed_ff     <= RST_HASH_SEED;
         threshold_ff     <= RST_THRESHOLD;
         bucket_bits_ff   <= RST_BUCKET_BITS;
      end else if (csr_beat) begin
         case (csr_index)
            CSR_WINDOW_LENGTH:      window_length_ff <= csr_data[WL_W-1:0];
            CSR_HASH_SEED:          hash_seed_ff     <= csr_data;
            CSR_LOW_HASH_THRESHOLD: threshold_ff     <= csr_data;
            CSR_BUCKET_BITS:        bucket_bits_ff   <= csr_data[BB_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp the window length to 1..MAX_WINDOW
   assign wl_ext = LEN_W'(window_length_ff);
   always_comb begin
      eff_len = wl_ext;
      if (wl_ext == '0)                     eff_len = LEN_W'(1);
      else if (wl_ext > LEN_W'(MAX_WINDOW)) eff_len = LEN_W'(MAX_WINDOW);
   end

   always_comb begin
      fill_in = fill_ff;
      if (req_beat) begin
         if (req_data.first_of_read)              fill_in = CNT_W'(1);
         else if (fill_ff != CNT_W'(MAX_WINDOW))  fill_in = fill_ff + 1'b1;
      end
   end

   assign start = req_beat && !req_data.read_is_palindromic
                  && (LEN_W'(fill_in) >= eff_len);

   assign hash_low  = hash < threshold_ff;
   assign done_step = busy && (ctrl.uop == UOP_DONE);
   // hold the last step while an earlier result still waits
   assign stall     = done_step && hash_low && rsp_valid_ff && !rsp_ready;

   whs_sequencer #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .stall   (stall),
      .eff_len (eff_len),
      .ctrl    (ctrl),
      .busy    (busy),
      .step_en (step_en)
   );

   whs_datapath #(
      .MAX_WINDOW   (MAX_WINDOW),
      .KMER_ID_BITS (KMER_ID_BITS)
   ) u_dp (
      .clock     (clock),
      .shift_en  (req_beat),
      .kmer_id   (req_data.kmer_id),
      .step_en   (step_en),
      .ctrl      (ctrl),
      .eff_len   (eff_len),
      .hash_seed (hash_seed_ff),
      .hash      (hash)
   );

   assign bucket_mask = (32'd1 << bucket_bits_ff) - 32'd1;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (done_step && step_en && hash_low) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.low_hash     = hash;
         rsp_data_in.bucket_index = hash[BUCKET_W-1:0] & bucket_mask[BUCKET_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule
